FILE: hdl/mpd_pkg.sv
// shared types, codes and helpers for the ps/2 mouse packet decoder
// no dependencies; imported by every module of the block
package mpd_pkg;

	// operation codes of an input beat
	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_POLL = 1'b1;

	// header byte bit positions
	localparam int HDR_SYNC_BIT  = 3;
	localparam int HDR_XSIGN_BIT = 4;
	localparam int HDR_YSIGN_BIT = 5;
	localparam int HDR_XOVF_BIT  = 6;
	localparam int HDR_YOVF_BIT  = 7;

	// saturation limits
	localparam logic signed [15:0] XY_LIMIT = 16'sd32767;
	localparam logic signed [11:0] Z_LIMIT  = 12'sd2047;

	// byte position within a packet
	typedef enum logic [1:0] {
		POS_HEAD  = 2'd0,
		POS_X     = 2'd1,
		POS_Y     = 2'd2,
		POS_WHEEL = 2'd3
	} pos_t;

	typedef struct packed {
		logic       op;
		logic [7:0] data_byte;
	} beat_t;

	typedef struct packed {
		logic               got_any;
		logic signed [15:0] dx;
		logic signed [15:0] dy;
		logic signed [11:0] dz;
		logic [2:0]         buttons;
		logic               buttons_changed;
	} res_t;

	// clamp a 17-bit sum to +-32767
	function automatic logic signed [15:0] sat_xy(input logic signed [16:0] v);
		logic signed [16:0] hi;
		logic signed [16:0] lo;
		hi = {XY_LIMIT[15], XY_LIMIT};
		lo = -hi;
		if (v > hi) return XY_LIMIT;
		else if (v < lo) return -XY_LIMIT;
		else return v[15:0];
	endfunction

	// clamp a 13-bit sum to +-2047
	function automatic logic signed [11:0] sat_z(input logic signed [12:0] v);
		logic signed [12:0] hi;
		logic signed [12:0] lo;
		hi = {Z_LIMIT[11], Z_LIMIT};
		lo = -hi;
		if (v > hi) return Z_LIMIT;
		else if (v < lo) return -Z_LIMIT;
		else return v[11:0];
	endfunction

endpackage

FILE: hdl/mpd_core.sv
// packet assembly, motion accumulation and poll result generation
// depends on mpd_pkg
module mpd_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_wr_en,
	input  logic          cfg_wr_data,
	input  logic          beat_valid,
	input  mpd_pkg::beat_t beat,
	output logic          res_valid,
	output mpd_pkg::res_t res
);
	import mpd_pkg::*;

	pos_t               pos_q, pos_d;
	logic               wheel_mode_q;
	logic [7:0]         hdr_q, hdr_d;
	logic [7:0]         x_q, x_d;
	logic [7:0]         y_q, y_d;
	logic signed [15:0] sum_x_q, sum_x_d;
	logic signed [15:0] sum_y_q, sum_y_d;
	logic signed [11:0] sum_z_q, sum_z_d;
	logic [2:0]         pend_q, pend_d;
	logic               seen_q, seen_d;
	logic [2:0]         rep_q, rep_d;

	logic [7:0]         b;
	logic [7:0]         y_byte;
	logic signed [8:0]  x_del;
	logic signed [8:0]  y_del;
	logic signed [3:0]  z_del;
	logic signed [15:0] x_fin;
	logic signed [15:0] y_fin;
	logic signed [11:0] z_fin;

	assign b = beat.data_byte;

	// y comes straight from the byte when a three-byte packet closes on it
	assign y_byte = (pos_q == POS_Y) ? b : y_q;
	assign x_del  = hdr_q[HDR_XOVF_BIT] ? 9'sd0 : $signed({hdr_q[HDR_XSIGN_BIT], x_q});
	assign y_del  = hdr_q[HDR_YOVF_BIT] ? 9'sd0 : $signed({hdr_q[HDR_YSIGN_BIT], y_byte});
	assign z_del  = (pos_q == POS_WHEEL && wheel_mode_q) ? $signed(b[3:0]) : 4'sd0;

	assign x_fin = sat_xy($signed({sum_x_q[15], sum_x_q}) + $signed({{8{x_del[8]}}, x_del}));
	assign y_fin = sat_xy($signed({sum_y_q[15], sum_y_q}) + $signed({{8{y_del[8]}}, y_del}));
	assign z_fin = sat_z($signed({sum_z_q[11], sum_z_q}) + $signed({{9{z_del[3]}}, z_del}));

	// poll result straight from the current state
	assign res.got_any         = seen_q;
	assign res.dx              = sum_x_q;
	assign res.dy              = -sum_y_q;
	assign res.dz              = sum_z_q;
	assign res.buttons         = pend_q;
	assign res.buttons_changed = (pend_q != rep_q);

	always_comb begin
		pos_d     = pos_q;
		hdr_d     = hdr_q;
		x_d       = x_q;
		y_d       = y_q;
		sum_x_d   = sum_x_q;
		sum_y_d   = sum_y_q;
		sum_z_d   = sum_z_q;
		pend_d    = pend_q;
		seen_d    = seen_q;
		rep_d     = rep_q;
		res_valid = 1'b0;
		if (beat_valid) begin
			if (beat.op == OP_BYTE) begin
				unique case (pos_q)
					POS_HEAD: begin
						if (b[HDR_SYNC_BIT]) begin
							hdr_d = b;
							pos_d = POS_X;
						end
					end
					POS_X: begin
						x_d   = b;
						pos_d = POS_Y;
					end
					POS_Y: begin
						y_d = b;
						if (wheel_mode_q) begin
							pos_d = POS_WHEEL;
						end else begin
							sum_x_d = x_fin;
							sum_y_d = y_fin;
							sum_z_d = z_fin;
							pend_d  = hdr_q[2:0];
							seen_d  = 1'b1;
							pos_d   = POS_HEAD;
						end
					end
					POS_WHEEL: begin
						sum_x_d = x_fin;
						sum_y_d = y_fin;
						sum_z_d = z_fin;
						pend_d  = hdr_q[2:0];
						seen_d  = 1'b1;
						pos_d   = POS_HEAD;
					end
					default: pos_d = POS_HEAD;
				endcase
			end else begin
				res_valid = 1'b1;
				sum_x_d   = 16'sd0;
				sum_y_d   = 16'sd0;
				sum_z_d   = 12'sd0;
				seen_d    = 1'b0;
				rep_d     = pend_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= POS_HEAD;
			wheel_mode_q <= 1'b0;
			sum_x_q      <= 16'sd0;
			sum_y_q      <= 16'sd0;
			sum_z_q      <= 12'sd0;
			pend_q       <= 3'd0;
			seen_q       <= 1'b0;
			rep_q        <= 3'd0;
		end else begin
			pos_q   <= pos_d;
			sum_x_q <= sum_x_d;
			sum_y_q <= sum_y_d;
			sum_z_q <= sum_z_d;
			pend_q  <= pend_d;
			seen_q  <= seen_d;
			rep_q   <= rep_d;
			if (cfg_wr_en) begin
				wheel_mode_q <= cfg_wr_data;
			end
		end
	end

	// packet byte stores, no reset needed
	always_ff @(posedge clk) begin
		hdr_q <= hdr_d;
		x_q   <= x_d;
		y_q   <= y_d;
	end

	// sums never reach the most negative code
	a_sum_range: assert property (@(posedge clk) disable iff (!arst_n)
		(sum_x_q != 16'sh8000) && (sum_y_q != 16'sh8000) && (sum_z_q != 12'sh800))
		else $error("motion sum outside saturation range");

	// a poll always leaves the sums and the packet flag clear
	a_poll_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(beat_valid && beat.op == OP_POLL) |=> (!seen_q && sum_x_q == 16'sd0
			&& sum_y_q == 16'sd0 && sum_z_q == 12'sd0))
		else $error("poll did not clear accumulated state");

	// leaving the header slot needs a byte with the sync bit
	a_sync: assert property (@(posedge clk) disable iff (!arst_n)
		(pos_q == POS_HEAD && pos_d == POS_X) |-> (beat_valid && b[HDR_SYNC_BIT]))
		else $error("packet started without sync bit");

endmodule

FILE: hdl/mpd_out_buf.sv
// two-entry result buffer between the decoder core and the output channel
// depends on mpd_pkg
module mpd_out_buf (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  mpd_pkg::res_t push_res,
	output logic          full,
	output logic          out_valid,
	input  logic          out_stall,
	output mpd_pkg::res_t out_res
);
	import mpd_pkg::*;

	res_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       pop;

	assign out_valid = (count_q != 2'd0);
	assign full      = (count_q == 2'd2);
	assign pop       = out_valid && !out_stall;
	assign out_res   = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_res;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("result pushed into full buffer");

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("result count out of range");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd1 && pop && !push) |=> !out_valid)
		else $error("buffer did not drain after last beat");

endmodule

FILE: hdl/ps2_mouse_packet_decoder.sv
// top level of the ps/2 mouse packet decoder
// depends on mpd_pkg, mpd_core and mpd_out_buf
//
//  - input channel (in_valid / in_stall): each beat carries op and data_byte.
//    op byte delivers one raw mouse byte and yields no result; op poll
//    yields exactly one result beat and clears the accumulated motion.
//  - output channel (out_valid / out_stall): got_any, dx, dy, dz, buttons,
//    buttons_changed for each poll, in poll order.
//  - cfg_wr_en / cfg_wr_data write wheel_mode (0: three-byte packets,
//    1: four-byte packets with a wheel nibble); write it only while idle.
//  - an accepted beat is held in the input register and applied to the state
//    when it advances; that update also writes a poll result into the result
//    buffer, which raises out_valid.
//  - throughput: one beat per cycle while in_stall is low, set by the single state
//    update pass in the core; polls flow while the two-entry result buffer has room.
//  - when the receiver stalls, results collect in the buffer; once it is
//    full a poll waits in the input register and in_stall goes high. byte
//    beats never wait on the output side.
//  - reset clears position, sums, button history, wheel_mode and both registers.
module ps2_mouse_packet_decoder (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic               cfg_wr_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               op,
	input  logic [7:0]         data_byte,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               got_any,
	output logic signed [15:0] dx,
	output logic signed [15:0] dy,
	output logic signed [11:0] dz,
	output logic [2:0]         buttons,
	output logic               buttons_changed
);
	import mpd_pkg::*;

	// input register
	logic  valid_s1;
	beat_t beat_s1;

	logic  advance;
	logic  res_valid;
	res_t  res;
	logic  buf_full;
	res_t  out_res;

	// a byte beat always moves on, a poll needs room for its result
	assign advance  = valid_s1 && (beat_s1.op == OP_BYTE || !buf_full);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// payload holds while stalled
	always_ff @(posedge clk) begin
		if (!in_stall) begin
			beat_s1.op        <= op;
			beat_s1.data_byte <= data_byte;
		end
	end

	mpd_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.beat_valid (advance),
		.beat       (beat_s1),
		.res_valid  (res_valid),
		.res        (res)
	);

	// result register with skid room
	mpd_out_buf u_out_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (res_valid),
		.push_res (res),
		.full     (buf_full),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_res  (out_res)
	);

	assign got_any         = out_res.got_any;
	assign dx              = out_res.dx;
	assign dy              = out_res.dy;
	assign dz              = out_res.dz;
	assign buttons         = out_res.buttons;
	assign buttons_changed = out_res.buttons_changed;

endmodule
